// File: sv/dks_pkg.sv
// Shared types, constants and permutation functions for the DES key schedule.
// No dependencies; imported by every module of the block.
package dks_pkg;

   localparam int KEY_BITS    = 64;
   localparam int HALF_BITS   = 28;
   localparam int CD_BITS     = 2 * HALF_BITS;
   localparam int SUBKEY_BITS = 48;
   localparam int ROUND_BITS  = 5;

   localparam logic [ROUND_BITS-1:0] FIRST_ROUND      = ROUND_BITS'(1);
   localparam logic [ROUND_BITS-1:0] SECOND_ROUND     = ROUND_BITS'(2);
   localparam logic [ROUND_BITS-1:0] MID_SINGLE_ROUND = ROUND_BITS'(9);
   localparam logic [ROUND_BITS-1:0] LAST_ROUND       = ROUND_BITS'(16);
   localparam logic [ROUND_BITS-1:0] NO_ROUND         = ROUND_BITS'(0);

   // Command codes
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // Parity-drop table: source bit of the key for each output bit,
   // bits counted from the most significant end starting at one
   localparam int unsigned PC1_TAB [CD_BITS] = '{
      57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
      10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
      63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
      14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
   };

   // Compression table: source bit of C||D for each subkey bit,
   // counted the same way from the most significant end
   localparam int unsigned PC2_TAB [SUBKEY_BITS] = '{
      14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
      23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
      41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
      44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
   };

   typedef struct packed {
      logic                cmd;
      logic [KEY_BITS-1:0] key_word;
   } req_type;

   typedef struct packed {
      logic [ROUND_BITS-1:0]  round_index;
      logic [SUBKEY_BITS-1:0] subkey;
   } rsp_type;

   // Parity drop: 64-bit key to C||D
   function automatic logic [CD_BITS-1:0] pc1_perm(input logic [KEY_BITS-1:0] key);
      logic [CD_BITS-1:0] cd;
      cd = '0;
      for (int i = 0; i < CD_BITS; i++) begin
         cd[CD_BITS-1-i] = key[KEY_BITS - PC1_TAB[i]];
      end
      return cd;
   endfunction

   // Compression: C||D to 48-bit subkey
   function automatic logic [SUBKEY_BITS-1:0] pc2_perm(input logic [CD_BITS-1:0] cd);
      logic [SUBKEY_BITS-1:0] sk;
      sk = '0;
      for (int i = 0; i < SUBKEY_BITS; i++) begin
         sk[SUBKEY_BITS-1-i] = cd[CD_BITS - PC2_TAB[i]];
      end
      return sk;
   endfunction

   // Left rotate of one half by one or two places
   function automatic logic [HALF_BITS-1:0] rot_half(input logic [HALF_BITS-1:0] v,
                                                     input logic              by_one);
      if (by_one) begin
         return {v[HALF_BITS-2:0], v[HALF_BITS-1]};
      end
      return {v[HALF_BITS-3:0], v[HALF_BITS-1:HALF_BITS-2]};
   endfunction

endpackage

// File: sv/dks_round.sv
// Round engine: C/D half registers and round counter, next-round logic and compression.
// Depends on dks_pkg.
module dks_round import dks_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req,
   output rsp_type result
);

   logic [HALF_BITS-1:0]  c_ff, c_in;
   logic [HALF_BITS-1:0]  d_ff, d_in;
   logic [ROUND_BITS-1:0] round_ff, round_in;
   logic [CD_BITS-1:0]    loaded_cd;
   logic [HALF_BITS-1:0]  c_base, d_base;
   logic                  shift_one;

   // Next round number; a load restarts at round one, sixteen wraps
   always_comb begin
      if (req.cmd == CMD_LOAD) begin
         round_in = FIRST_ROUND;
      end else if (round_ff == NO_ROUND || round_ff >= LAST_ROUND) begin
         round_in = FIRST_ROUND;
      end else begin
         round_in = round_ff + FIRST_ROUND;
      end
   end

   // Half selection and rotation
   always_comb begin
      loaded_cd = pc1_perm(req.key_word);
      shift_one = (round_in == FIRST_ROUND) || (round_in == SECOND_ROUND) ||
                  (round_in == MID_SINGLE_ROUND) || (round_in == LAST_ROUND);
      if (req.cmd == CMD_LOAD) begin
         c_base = loaded_cd[CD_BITS-1:HALF_BITS];
         d_base = loaded_cd[HALF_BITS-1:0];
      end else begin
         c_base = c_ff;
         d_base = d_ff;
      end
      c_in = rot_half(c_base, shift_one);
      d_in = rot_half(d_base, shift_one);
   end

   // Subkey of the round being taken
   always_comb begin
      result.round_index = round_in;
      result.subkey      = pc2_perm({c_in, d_in});
   end

   // Schedule state, updated once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff     <= '0;
         d_ff     <= '0;
         round_ff <= NO_ROUND;
      end else if (fire) begin
         c_ff     <= c_in;
         d_ff     <= d_in;
         round_ff <= round_in;
      end
   end

endmodule

// File: sv/dks_outbuf.sv
// Output register with a skid entry, so the input side waits on a stall only once the skid entry is full.
// Depends on dks_pkg.
module dks_outbuf import dks_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;
   logic    in_fire;
   logic    out_free;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_free  = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || in_fire;
         skid_valid_ff <= 1'b0;
      end else if (in_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_fire) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

// File: sv/des_key_schedule.sv
// DES round-key generator top level: round engine feeding a skid output buffer.
// Depends on dks_pkg, dks_round and dks_outbuf.
//
//   channel | dir | ports                           | moves
//   req     | in  | req_valid, req_ready, req_data  | cmd, key_word
//   rsp     | out | rsp_valid, rsp_ready, rsp_data  | round_index, subkey
//
// One transaction per cycle while req_ready is high; each result is registered in the output buffer.
// The half rotate and both bit permutations are combinational: wiring plus a 2:1 mux.
// A stalled result parks in the skid entry; req_ready drops only while it is full.
// Synchronous reset clears halves, round counter and the valid flags of both buffer entries.
module des_key_schedule import dks_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    req_fire;
   rsp_type round_result;

   assign req_fire = req_valid && req_ready;

   dks_round u_round (
      .clock  (clock),
      .reset  (reset),
      .fire   (req_fire),
      .req    (req_data),
      .result (round_result)
   );

   dks_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (round_result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

// File: sv/dks_checker.sv
// Port-level checks for des_key_schedule, bound to the top level.
// Depends on dks_pkg.
module dks_checker import dks_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Nothing pending straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Round number always in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.round_index >= FIRST_ROUND &&
                     rsp_data.round_index <= LAST_ROUND))
      else $error("round_index out of range");

   // Back-to-back results carry consecutive rounds, or a restart at one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) ##1 (rsp_valid && rsp_ready) |->
         (rsp_data.round_index == FIRST_ROUND ||
          rsp_data.round_index == $past(rsp_data.round_index) + FIRST_ROUND))
      else $error("round sequence broken");

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind des_key_schedule dks_checker u_dks_checker (.*);
